[rtl/achsw_pkg.sv]
// Shared types, command codes and dial lookup tables for the analog clock
// hand segment writer. No dependencies.
package achsw_pkg;

   localparam logic [1:0] CMD_SEGMENT = 2'd0;
   localparam logic [1:0] CMD_LED     = 2'd1;
   localparam logic [1:0] CMD_REFRESH = 2'd2;
   localparam logic [1:0] CMD_ERROR   = 2'd3;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [4:0] hour_value;
      logic [5:0] minute_value;
      logic [5:0] second_value;
   } req_type;

   typedef struct packed {
      logic [1:0] command_kind;
      logic [4:0] segment_number;
      logic [3:0] grid_number;
      logic       bit_on;
      logic       last_of_run;
   } rsp_type;

   // One classified request, as handed from the front part to the back part.
   typedef struct packed {
      logic       is_error;
      logic [5:0] old_hour;
      logic [5:0] new_hour;
      logic [5:0] old_minute;
      logic       minute_shared;
      logic [5:0] new_minute;
      logic [5:0] old_second;
      logic       second_clear_lower;
      logic       second_clear_upper;
      logic [5:0] new_second;
      logic       led_bit;
   } plan_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam logic [4:0] LOWER_SEG [64] = '{
      5'd15, 5'd14, 5'd11, 5'd10, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd16,
      5'd15, 5'd14, 5'd11, 5'd10, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd16,
      5'd15, 5'd14, 5'd11, 5'd10, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd16,
      5'd15, 5'd14, 5'd11, 5'd10, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd16,
      5'd15, 5'd14, 5'd11, 5'd10, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd16,
      5'd15, 5'd14, 5'd11, 5'd10, 5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd16,
      5'd0, 5'd0, 5'd0, 5'd0
   };

   localparam logic [4:0] UPPER_SEG [64] = '{
      5'd8, 5'd7, 5'd4, 5'd3, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd9,
      5'd8, 5'd7, 5'd4, 5'd3, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd9,
      5'd8, 5'd7, 5'd4, 5'd3, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd9,
      5'd8, 5'd7, 5'd4, 5'd3, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd9,
      5'd8, 5'd7, 5'd4, 5'd3, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd9,
      5'd8, 5'd7, 5'd4, 5'd3, 5'd9, 5'd8, 5'd7, 5'd6, 5'd5, 5'd9,
      5'd0, 5'd0, 5'd0, 5'd0
   };

   localparam logic [3:0] RING_GRID [64] = '{
      4'd12, 4'd12, 4'd12, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
      4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4,
      4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6, 4'd6,
      4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd8,
      4'd8, 4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10,
      4'd10, 4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd12, 4'd12,
      4'd0, 4'd0, 4'd0, 4'd0
   };

endpackage

[rtl/analog_clock_hand_segment_writer.sv]
// Top level of the analog clock hand segment writer: front part, request
// queue and back part. Uses achsw_pkg, achsw_front, achsw_queue, achsw_back.
//
// Each request carries a time of day. For an in-range time the block emits
// 9 to 12 results: segment writes that clear and redraw the hour, minute and
// second hands on the 60-position dial, then an LED set with a value that
// alternates from one valid request to the next, then a display refresh.
// An out-of-range time gives a single range error result and changes nothing.
// The final result of every request has last_of_run set.
// On an idle block, an accepted request is written into the queue and then
// loaded into the result register before rsp_valid rises.
// The back part emits one result per cycle while the receiver does not stall,
// and holds each request until its last result; this command sequencer sets the
// sustained rate. Up to two classified requests wait in the queue, so the
// next request is taken while earlier results are still being emitted.
// When the receiver stalls, the result register holds, the queue fills and
// req_ready drops. Reset clears the hand positions and LED phase to zero and
// empties the queue and the result register.
module analog_clock_hand_segment_writer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  achsw_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output achsw_pkg::rsp_type  rsp_payload
);

   achsw_pkg::queue_status_type  queue_status;
   achsw_pkg::plan_type          push_plan;
   achsw_pkg::plan_type          head_plan;
   logic                         push;
   logic                         pop;

   achsw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .queue_status (queue_status),
      .push         (push),
      .push_plan    (push_plan)
   );

   achsw_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_plan    (push_plan),
      .pop          (pop),
      .head_plan    (head_plan),
      .queue_status (queue_status)
   );

   achsw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_plan    (head_plan),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

endmodule

[rtl/achsw_front.sv]
// Front part: accepts time requests, checks ranges, computes the hour hand
// position and the clearing decisions, and keeps the hand state. Uses achsw_pkg.
module achsw_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  achsw_pkg::req_type           req_payload,
   input  achsw_pkg::queue_status_type  queue_status,
   output logic                         push,
   output achsw_pkg::plan_type          push_plan
);

   logic [5:0] hour_pos_ff, hour_pos_in;
   logic [5:0] minute_pos_ff, minute_pos_in;
   logic [5:0] second_pos_ff, second_pos_in;
   logic       led_phase_ff, led_phase_in;
   logic       range_error;
   logic [3:0] hour_twelve;
   logic [2:0] minute_fifth;
   logic [5:0] hour_hand;

   assign req_ready = !queue_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      range_error = (req_payload.hour_value > 5'd23) || (req_payload.minute_value > 6'd59)
                    || (req_payload.second_value > 6'd59);
      if (req_payload.hour_value >= 5'd12) begin
         hour_twelve = 4'(req_payload.hour_value - 5'd12);
      end else begin
         hour_twelve = req_payload.hour_value[3:0];
      end
      priority if (req_payload.minute_value >= 6'd48) begin
         minute_fifth = 3'd4;
      end else if (req_payload.minute_value >= 6'd36) begin
         minute_fifth = 3'd3;
      end else if (req_payload.minute_value >= 6'd24) begin
         minute_fifth = 3'd2;
      end else if (req_payload.minute_value >= 6'd12) begin
         minute_fifth = 3'd1;
      end else begin
         minute_fifth = 3'd0;
      end
      hour_hand = 6'({hour_twelve, 2'b00}) + 6'(hour_twelve) + 6'(minute_fifth);

      push_plan.is_error           = range_error;
      push_plan.old_hour           = hour_pos_ff;
      push_plan.new_hour           = hour_hand;
      push_plan.old_minute         = minute_pos_ff;
      push_plan.minute_shared      = (minute_pos_ff == hour_hand);
      push_plan.new_minute         = req_payload.minute_value;
      push_plan.old_second         = second_pos_ff;
      push_plan.second_clear_lower = (second_pos_ff != hour_hand)
                                     && (second_pos_ff != req_payload.minute_value);
      push_plan.second_clear_upper = (second_pos_ff != req_payload.minute_value);
      push_plan.new_second         = req_payload.second_value;
      push_plan.led_bit            = led_phase_ff;

      hour_pos_in   = hour_pos_ff;
      minute_pos_in = minute_pos_ff;
      second_pos_in = second_pos_ff;
      led_phase_in  = led_phase_ff;
      if (push && !range_error) begin
         hour_pos_in   = hour_hand;
         minute_pos_in = req_payload.minute_value;
         second_pos_in = req_payload.second_value;
         led_phase_in  = !led_phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_pos_ff   <= '0;
         minute_pos_ff <= '0;
         second_pos_ff <= '0;
         led_phase_ff  <= 1'b0;
      end else begin
         hour_pos_ff   <= hour_pos_in;
         minute_pos_ff <= minute_pos_in;
         second_pos_ff <= second_pos_in;
         led_phase_ff  <= led_phase_in;
      end
   end

endmodule

[rtl/achsw_queue.sv]
// Two-entry queue of classified requests between the front and back parts.
// Uses achsw_pkg.
module achsw_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  achsw_pkg::plan_type          push_plan,
   input  logic                         pop,
   output achsw_pkg::plan_type          head_plan,
   output achsw_pkg::queue_status_type  queue_status
);

   localparam int PtrWidth   = $clog2(achsw_pkg::QUEUE_DEPTH);
   localparam int CountWidth = $clog2(achsw_pkg::QUEUE_DEPTH + 1);

   achsw_pkg::plan_type entry_ff [achsw_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign head_plan          = entry_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == CountWidth'(achsw_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(achsw_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(achsw_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

endmodule

[rtl/achsw_back.sv]
// Back part: steps through the queue head's command sequence into a registered
// result stage, one command per cycle while not stalled. Uses achsw_pkg.
module achsw_back (
   input  logic                         clock,
   input  logic                         reset,
   input  achsw_pkg::plan_type          head_plan,
   input  achsw_pkg::queue_status_type  queue_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output achsw_pkg::rsp_type           rsp_payload
);

   localparam logic [3:0] ST_H_CLR    = 4'd0;
   localparam logic [3:0] ST_H_SET    = 4'd1;
   localparam logic [3:0] ST_M_CLR_LO = 4'd2;
   localparam logic [3:0] ST_M_CLR_UP = 4'd3;
   localparam logic [3:0] ST_M_SET_LO = 4'd4;
   localparam logic [3:0] ST_M_SET_UP = 4'd5;
   localparam logic [3:0] ST_S_CLR_LO = 4'd6;
   localparam logic [3:0] ST_S_CLR_UP = 4'd7;
   localparam logic [3:0] ST_S_SET_LO = 4'd8;
   localparam logic [3:0] ST_S_SET_UP = 4'd9;
   localparam logic [3:0] ST_LED      = 4'd10;
   localparam logic [3:0] ST_REFRESH  = 4'd11;

   logic [3:0]          step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   achsw_pkg::rsp_type  rsp_payload_ff, rsp_payload_in;
   logic                load;
   logic [3:0]          step_next;
   logic [5:0]          pos;
   logic                upper_ring;
   logic                seg_bit;
   logic [1:0]          kind;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign load        = !queue_status.empty && (!rsp_valid_ff || rsp_ready);
   assign pop         = load && (head_plan.is_error || (step_ff == ST_REFRESH));

   always_comb begin
      pos        = head_plan.old_hour;
      upper_ring = 1'b0;
      seg_bit    = 1'b0;
      kind       = achsw_pkg::CMD_SEGMENT;
      step_next  = ST_H_CLR;
      unique case (step_ff)
         ST_H_CLR: begin
            step_next = ST_H_SET;
         end
         ST_H_SET: begin
            pos       = head_plan.new_hour;
            seg_bit   = 1'b1;
            step_next = head_plan.minute_shared ? ST_M_CLR_UP : ST_M_CLR_LO;
         end
         ST_M_CLR_LO: begin
            pos       = head_plan.old_minute;
            step_next = ST_M_CLR_UP;
         end
         ST_M_CLR_UP: begin
            pos        = head_plan.old_minute;
            upper_ring = 1'b1;
            step_next  = ST_M_SET_LO;
         end
         ST_M_SET_LO: begin
            pos       = head_plan.new_minute;
            seg_bit   = 1'b1;
            step_next = ST_M_SET_UP;
         end
         ST_M_SET_UP: begin
            pos        = head_plan.new_minute;
            upper_ring = 1'b1;
            seg_bit    = 1'b1;
            priority if (head_plan.second_clear_lower) begin
               step_next = ST_S_CLR_LO;
            end else if (head_plan.second_clear_upper) begin
               step_next = ST_S_CLR_UP;
            end else begin
               step_next = ST_S_SET_LO;
            end
         end
         ST_S_CLR_LO: begin
            pos       = head_plan.old_second;
            step_next = ST_S_CLR_UP;
         end
         ST_S_CLR_UP: begin
            pos        = head_plan.old_second;
            upper_ring = 1'b1;
            step_next  = ST_S_SET_LO;
         end
         ST_S_SET_LO: begin
            pos       = head_plan.new_second;
            seg_bit   = 1'b1;
            step_next = ST_S_SET_UP;
         end
         ST_S_SET_UP: begin
            pos        = head_plan.new_second;
            upper_ring = 1'b1;
            seg_bit    = 1'b1;
            step_next  = ST_LED;
         end
         ST_LED: begin
            kind      = achsw_pkg::CMD_LED;
            seg_bit   = head_plan.led_bit;
            step_next = ST_REFRESH;
         end
         ST_REFRESH: begin
            kind      = achsw_pkg::CMD_REFRESH;
            step_next = ST_H_CLR;
         end
         default: begin
            step_next = ST_H_CLR;
         end
      endcase

      if (head_plan.is_error) begin
         kind      = achsw_pkg::CMD_ERROR;
         seg_bit   = 1'b0;
         step_next = ST_H_CLR;
      end

      rsp_payload_in.command_kind = kind;
      rsp_payload_in.bit_on       = seg_bit;
      rsp_payload_in.last_of_run  = (kind == achsw_pkg::CMD_ERROR)
                                    || (kind == achsw_pkg::CMD_REFRESH);
      if (kind == achsw_pkg::CMD_SEGMENT) begin
         rsp_payload_in.segment_number = upper_ring ? achsw_pkg::UPPER_SEG[pos]
                                         : achsw_pkg::LOWER_SEG[pos];
         rsp_payload_in.grid_number    = achsw_pkg::RING_GRID[pos];
      end else begin
         rsp_payload_in.segment_number = '0;
         rsp_payload_in.grid_number    = '0;
      end

      step_in      = load ? step_next : step_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_H_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

[rtl/achsw_checker.sv]
// Port-level checks for the analog clock hand segment writer, bound to the
// top level. Uses achsw_pkg.
module achsw_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input achsw_pkg::req_type  req_payload,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input achsw_pkg::rsp_type  rsp_payload
);

   logic req_seen;
   assign req_seen = req_valid && req_ready && (req_payload.hour_value != 5'd31);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result changed while stalled.");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_of_run |->
         (rsp_payload.command_kind == achsw_pkg::CMD_REFRESH)
         || (rsp_payload.command_kind == achsw_pkg::CMD_ERROR))
      else $error("Run ended on a command other than refresh or error.");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_payload.command_kind == achsw_pkg::CMD_REFRESH)
         || (rsp_payload.command_kind == achsw_pkg::CMD_ERROR)) |->
         rsp_payload.last_of_run && !rsp_payload.bit_on)
      else $error("Refresh or error result is malformed.");

   a_segment_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.command_kind == achsw_pkg::CMD_SEGMENT) |->
         (rsp_payload.grid_number != 4'd0) && (rsp_payload.segment_number >= 5'd3)
         && (rsp_payload.segment_number <= 5'd16))
      else $error("Segment write addresses no dial position.");

   a_first_result: assert property (@(posedge clock) disable iff (reset)
      req_seen && !rsp_valid && !$past(rsp_valid) |=> 1'b1 ##1 rsp_valid)
      else $error("No result two cycles after a request into an idle block.");

endmodule

bind analog_clock_hand_segment_writer achsw_checker u_achsw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
